[rtl/rcfm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfm_pkg: shared types and constants of the reference clock frequency meter
// Beat payloads, state encodings, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package rcfm_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_REF_FREQ = 2'd0;
   localparam logic [1:0] CSR_TARGET   = 2'd1;
   localparam logic [1:0] CSR_WRAP     = 2'd2;

   localparam logic [31:0] REF_FREQ_RESET = 32'd3579545;
   localparam logic [31:0] TARGET_RESET   = 32'd357954;
   localparam logic        WRAP_RESET     = 1'b1;

   // Action codes of a request beat.
   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] SPAN24     = 32'h0100_0000;
   // A wrapped 32-bit difference at or above this value means a backward
   // jump that fits in 24 bits.
   localparam logic [31:0] WRAP24_MIN = 32'hFF00_0001;

   // Measurement phase; the encoding is also the status code of a result.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_MEASURE = 2'd1,
      PH_READY   = 2'd2,
      PH_ERROR   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_CALC,
      ST_RESP
   } ctrl_state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_MUL0,
      U_MUL1,
      U_ADD,
      U_CHK,
      U_DIV,
      U_DONE
   } unit_state_type;

   typedef struct packed {
      logic        action;
      logic [63:0] ref_count;
      logic [63:0] cycle_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] freq_hz;
      logic [63:0] elapsed_ticks;
   } rsp_type;

   // Request to the shared multiply and divide unit.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] mul;
      logic [63:0] den;
   } calc_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } calc_rsp_type;

endpackage
`default_nettype wire

[rtl/rcfm_calc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfm_calc: iterative scaled quotient unit
// Forms num * mul with one 32x32 multiplier, low half first and high half next, then
// divides the 96-bit product by den one quotient bit a cycle, saturating at 64 bits.
// ----------------------------------------------------------------------------
module rcfm_calc (
   input  wire                      clock,
   input  wire                      reset,
   input  wire rcfm_pkg::calc_req_type req,
   output rcfm_pkg::calc_rsp_type   rsp
);
   import rcfm_pkg::*;

   unit_state_type state_ff, state_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] mul_ff, mul_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] plo_ff, plo_in;
   logic [63:0] phi_ff, phi_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [31:0] mul_a;
   logic [63:0] prod;
   logic [95:0] sum96;
   logic [64:0] sub_a;
   logic [65:0] sub_full;
   logic        sub_ge;

   // The one multiplier, shared by both halves of the numerator.
   assign mul_a = (state_ff == U_MUL0) ? num_ff[31:0] : num_ff[63:32];
   assign prod  = mul_a * mul_ff;
   assign sum96 = {phi_ff[63:0], 32'd0} + {32'd0, plo_ff};

   // The one subtractor: overflow check first, then each restoring step.
   assign sub_a    = (state_ff == U_DIV) ? {rem_ff, lo_ff[63]} : {1'b0, rem_ff};
   assign sub_full = {1'b0, sub_a} - {2'b00, den_ff};
   assign sub_ge   = ~sub_full[65];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE: if (req.start) state_in = U_MUL0;
         U_MUL0: state_in = U_MUL1;
         U_MUL1: state_in = U_ADD;
         U_ADD:  state_in = U_CHK;
         U_CHK:  state_in = sub_ge ? U_DONE : U_DIV;
         U_DIV:  if (cnt_ff == 6'd63) state_in = U_DONE;
         U_DONE: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      num_in = num_ff;
      mul_in = mul_ff;
      den_in = den_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      rem_in = rem_ff;
      lo_in  = lo_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               num_in = req.num;
               mul_in = req.mul;
               den_in = req.den;
            end
         end
         U_MUL0: plo_in = prod;
         U_MUL1: phi_in = prod;
         U_ADD: begin
            rem_in = {32'd0, sum96[95:64]};
            lo_in  = sum96[63:0];
         end
         U_CHK: begin
            cnt_in = 6'd0;
            if (sub_ge) begin
               lo_in = ALL_ONES64;
            end
         end
         U_DIV: begin
            // The quotient bits shift in behind the low dividend bits.
            rem_in = sub_ge ? sub_full[63:0] : sub_a[63:0];
            lo_in  = {lo_ff[62:0], sub_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         U_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff <= num_in;
      mul_ff <= mul_in;
      den_ff <= den_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = (state_ff == U_DONE);
   assign rsp.quotient = lo_ff;

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DIV && cnt_ff != 6'd63) |=> (state_ff == U_DIV))
      else $error("divide loop left early");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (req.start && state_ff == U_IDLE) |=> (state_ff == U_MUL0))
      else $error("unit did not take a start");
   // The done flag lasts exactly one cycle.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done)
      else $error("done flag held too long");

endmodule
`default_nettype wire

[rtl/reference_clock_frequency_meter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reference_clock_frequency_meter: cycle counter frequency meter
// Measures a fast cycle counter against a reference timer of known frequency.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         action, ref_count, cycle_count
//  rsp_     out        status, freq_hz, elapsed_ticks (one beat per request)
//  csr_     in         write of ref_freq_hz, target_ticks or wrap_mode
//
// A start beat passes from the prep state straight to the response state; a sample
// beat that does not trigger the calculation also passes the check state. The sample
// that reaches the target goes through the shared multiply and divide unit: the low and
// high multiply, an add, an overflow check and, unless that saturates, a restoring step per quotient bit.
// The request side is ready only while the controller is idle, but a new beat
// may be taken while the previous response still waits for rsp_ready.
// Reset is synchronous and restores the register defaults and an idle phase.
// ----------------------------------------------------------------------------
module reference_clock_frequency_meter (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire rcfm_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rcfm_pkg::rsp_type   rsp_data,
   input  wire                 csr_we,
   input  wire [1:0]           csr_index,
   input  wire [31:0]          csr_wdata
);
   import rcfm_pkg::*;

   // Configuration registers.
   logic [31:0] ref_freq_ff;
   logic [31:0] target_ff;
   logic        wrap_ff;

   ctrl_state_type state_ff, state_in;
   req_type     req_ff, req_in;
   phase_type   phase_ff, phase_in;
   logic [63:0] start_ref_ff, start_ref_in;
   logic [63:0] start_cyc_ff, start_cyc_in;
   logic [63:0] held_ff, held_in;
   logic [63:0] elapsed_ff, elapsed_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   calc_req_type calc_req;
   calc_rsp_type calc_rsp;

   logic        req_fire;
   logic        rsp_free;
   logic [31:0] diff32;
   logic [63:0] elapsed_calc;
   logic [63:0] goal;
   logic        goal_met;
   logic        cyc_back;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Elapsed reference ticks. In wrap mode only the low 32 bits count; a
   // backward jump that fits in 24 bits is taken as a 24-bit rollover, whose
   // true difference is the 32-bit wrapped difference plus 2^24.
   assign diff32 = req_ff.ref_count[31:0] - start_ref_ff[31:0];
   always_comb begin
      if (!wrap_ff) begin
         elapsed_calc = req_ff.ref_count - start_ref_ff;
      end else if (start_ref_ff[31:0] > req_ff.ref_count[31:0] && diff32 >= WRAP24_MIN) begin
         elapsed_calc = {32'd0, diff32 + SPAN24};
      end else begin
         elapsed_calc = {32'd0, diff32};
      end
   end

   // A target of zero counts as one, so the divisor is never zero.
   assign goal     = (target_ff == 32'd0) ? 64'd1 : {32'd0, target_ff};
   assign goal_met = (elapsed_ff >= goal);
   assign cyc_back = (req_ff.cycle_count < start_cyc_ff);

   assign calc_req.start = (state_ff == ST_CHECK) && (phase_ff == PH_MEASURE)
                           && goal_met && !cyc_back;
   assign calc_req.num   = req_ff.cycle_count - start_cyc_ff;
   assign calc_req.mul   = ref_freq_ff;
   assign calc_req.den   = elapsed_ff;

   rcfm_calc u_calc (
      .clock (clock),
      .reset (reset),
      .req   (calc_req),
      .rsp   (calc_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_PREP;
         ST_PREP:  state_in = (req_ff.action == ACT_START) ? ST_RESP : ST_CHECK;
         ST_CHECK: state_in = calc_req.start ? ST_CALC : ST_RESP;
         ST_CALC:  if (calc_rsp.done) state_in = ST_RESP;
         ST_RESP:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_in       = req_ff;
      phase_in     = phase_ff;
      start_ref_in = start_ref_ff;
      start_cyc_in = start_cyc_ff;
      held_in      = held_ff;
      elapsed_in   = elapsed_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
            end
         end
         ST_PREP: begin
            elapsed_in = elapsed_calc;
            if (req_ff.action == ACT_START) begin
               start_ref_in = req_ff.ref_count;
               start_cyc_in = req_ff.cycle_count;
               held_in      = 64'd0;
               phase_in     = PH_MEASURE;
               res_in       = '{status: 2'(PH_MEASURE), freq_hz: 64'd0,
                                elapsed_ticks: 64'd0};
            end
         end
         ST_CHECK: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  res_in = '{status: 2'(PH_IDLE), freq_hz: 64'd0,
                             elapsed_ticks: 64'd0};
               end
               PH_READY: begin
                  res_in = '{status: 2'(PH_READY), freq_hz: held_ff,
                             elapsed_ticks: elapsed_ff};
               end
               PH_ERROR: begin
                  res_in = '{status: 2'(PH_ERROR), freq_hz: 64'd0,
                             elapsed_ticks: elapsed_ff};
               end
               PH_MEASURE: begin
                  if (goal_met && cyc_back) begin
                     phase_in = PH_ERROR;
                     res_in   = '{status: 2'(PH_ERROR), freq_hz: 64'd0,
                                  elapsed_ticks: elapsed_ff};
                  end else begin
                     res_in   = '{status: 2'(PH_MEASURE), freq_hz: 64'd0,
                                  elapsed_ticks: elapsed_ff};
                  end
               end
               default: begin
               end
            endcase
         end
         ST_CALC: begin
            if (calc_rsp.done) begin
               held_in  = calc_rsp.quotient;
               phase_in = PH_READY;
               res_in   = '{status: 2'(PH_READY), freq_hz: calc_rsp.quotient,
                            elapsed_ticks: elapsed_ff};
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         start_ref_ff <= 64'd0;
         start_cyc_ff <= 64'd0;
         held_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
         ref_freq_ff  <= REF_FREQ_RESET;
         target_ff    <= TARGET_RESET;
         wrap_ff      <= WRAP_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         start_ref_ff <= start_ref_in;
         start_cyc_ff <= start_cyc_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_REF_FREQ: ref_freq_ff <= csr_wdata;
               CSR_TARGET:   target_ff   <= csr_wdata;
               CSR_WRAP:     wrap_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      req_ff      <= req_in;
      elapsed_ff  <= elapsed_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A frequency is only ever reported with the ready status.
   a_freq_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == 2'(PH_READY) || rsp_data_ff.freq_hz == 64'd0))
      else $error("frequency shown outside ready status");
   // An idle phase never keeps a stale result.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (held_ff == 64'd0))
      else $error("held result set while idle");
   // The shared unit finishes only while the controller waits for it.
   a_done_calc: assert property (@(posedge clock) disable iff (reset)
      calc_rsp.done |-> (state_ff == ST_CALC))
      else $error("unit finished outside calculation");
   // A finished calculation always leaves the phase ready.
   a_calc_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && calc_rsp.done) |=> (phase_ff == PH_READY))
      else $error("phase not ready after calculation");

endmodule
`default_nettype wire
